[hdl/euler_trs_model_matrix_defines.svh]
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_defines: assertion macros
// concurrent check macros clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef EULER_TRS_MODEL_MATRIX_DEFINES_SVH
`define EULER_TRS_MODEL_MATRIX_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked every cycle
`define ETRS_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("etrs check failed");
// same-cycle implication
`define ETRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("etrs implication failed");
// next-cycle implication
`define ETRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("etrs next-cycle check failed");
`else
`define ETRS_ASSERT(label, expr)
`define ETRS_ASSERT_IMPL(label, ante, cons)
`define ETRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/etrs_pkg.sv]
// ----------------------------------------------------------------------------
// etrs_pkg: shared types, constants and helpers
// fixed formats of the trig and matrix datapath
// ----------------------------------------------------------------------------
package etrs_pkg;

  localparam int IFRAC  = 30;  // fraction bits of sine, cosine and rotation terms
  localparam int ATAN_N = 24;
  localparam int FW     = 32;  // field width
  localparam int AW     = 35;  // offset angle during reduction
  localparam int ZW     = 38;  // residual angle, 1e-9 degree units
  localparam int XW     = 34;  // cordic x and y
  localparam int TRIG_W = 32;
  localparam int PW     = 33;  // rounded product of two trig terms
  localparam int RW     = 34;  // rotation element
  localparam int WW     = 66;  // rotation element times scale

  localparam logic [29:0] NDEG_PER_DEG = 30'd1000000000;

  typedef logic        [AW-1:0]     amod_t;
  typedef logic signed [ZW-1:0]     zang_t;
  typedef logic signed [XW-1:0]     cxy_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PW-1:0]     prod_t;
  typedef logic signed [RW-1:0]     relem_t;
  typedef logic signed [WW-1:0]     wide_t;
  typedef logic signed [FW-1:0]     field_t;

  // control handed from cell to cell
  typedef struct packed {
    logic vld;
    logic neg_s;
    logic neg_c;
  } sc_ctl_t;

  // pose data that bypasses the trig path
  typedef struct packed {
    field_t scale_z;
    field_t scale_y;
    field_t scale_x;
    field_t pos_z;
    field_t pos_y;
    field_t pos_x;
  } side_t;

  // atan(2^-i) in 1e-9 degree
  localparam zang_t ATAN_NDEG [ATAN_N] = '{
    38'sd45000000000, 38'sd26565051177, 38'sd14036243468, 38'sd7125016349,
    38'sd3576334375,  38'sd1789910608,  38'sd895173710,   38'sd447614171,
    38'sd223810500,   38'sd111905677,   38'sd55952892,    38'sd27976453,
    38'sd13988227,    38'sd6994114,     38'sd3497057,     38'sd1748528,
    38'sd874264,      38'sd437132,      38'sd218566,      38'sd109283,
    38'sd54642,       38'sd27321,       38'sd13660,       38'sd6830
  };

  // start value of x so that the rotated vector ends near unit length
  function automatic logic [IFRAC:0] cordic_gain(input int steps);
    logic [63:0] g;
    logic [63:0] k;
    logic [63:0] t;
    g = 64'd1 << IFRAC;
    k = '0;
    for (int i = 0; i < ATAN_N; i++) begin
      if (i < steps) begin
        g = g + (g >> (2 * i));
      end
    end
    for (int i = IFRAC - 1; i >= 0; i--) begin
      t = k | (64'd1 << i);
      if (((t * t) >> IFRAC) * g <= (64'd1 << 60)) begin
        k = t;
      end
    end
    return k[IFRAC:0];
  endfunction

  // product of two 30-fraction terms, rounded to 30 fraction bits
  function automatic prod_t mulq(input trig_t a, input trig_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd536870912;
    return p[62:30];
  endfunction

endpackage

[hdl/etrs_mod_cell.sv]
// ----------------------------------------------------------------------------
// etrs_mod_cell: one restoring step of the angle reduction
// subtracts its multiple of the full turn when the value allows
// ----------------------------------------------------------------------------
module etrs_mod_cell #(
  parameter etrs_pkg::amod_t SUB = 35'd1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  etrs_pkg::sc_ctl_t ctl_i,
  input  etrs_pkg::amod_t   val_i,
  output etrs_pkg::sc_ctl_t ctl_o,
  output etrs_pkg::amod_t   val_o
);
  import etrs_pkg::*;

  sc_ctl_t ctl_q;
  amod_t   val_d, val_q;

  assign val_d = (val_i >= SUB) ? (val_i - SUB) : val_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign ctl_o = ctl_q;
  assign val_o = val_q;

endmodule

[hdl/etrs_cordic_cell.sv]
// ----------------------------------------------------------------------------
// etrs_cordic_cell: one rotation-mode cordic iteration
// shift-add micro rotation with its fixed arctangent
// ----------------------------------------------------------------------------
module etrs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  etrs_pkg::sc_ctl_t ctl_i,
  input  etrs_pkg::cxy_t    x_i,
  input  etrs_pkg::cxy_t    y_i,
  input  etrs_pkg::zang_t   z_i,
  output etrs_pkg::sc_ctl_t ctl_o,
  output etrs_pkg::cxy_t    x_o,
  output etrs_pkg::cxy_t    y_o,
  output etrs_pkg::zang_t   z_o
);
  import etrs_pkg::*;

  localparam zang_t ATAN = ATAN_NDEG[STEP];

  sc_ctl_t ctl_q;
  cxy_t    dx, dy, x_d, y_d, x_q, y_q;
  zang_t   z_d, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[hdl/etrs_sincos.sv]
// ----------------------------------------------------------------------------
// etrs_sincos: sine and cosine of an angle in degrees
// modulo-360 reduction chain, quadrant fold, cordic chain, sign fix
// ----------------------------------------------------------------------------
`include "euler_trs_model_matrix_defines.svh"

module etrs_sincos #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16,
  parameter int RED_STEPS    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  etrs_pkg::field_t angle_i,
  output logic             vld_o,
  output etrs_pkg::trig_t  sin_o,
  output etrs_pkg::trig_t  cos_o
);
  import etrs_pkg::*;

  localparam longint unsigned FULL  = 64'd360 << FRAC_BITS;
  localparam longint unsigned HALF  = 64'd180 << FRAC_BITS;
  localparam longint unsigned QUART = 64'd90 << FRAC_BITS;
  localparam longint unsigned OFF   = FULL * (((64'd1 << 31) + FULL - 64'd1) / FULL);
  localparam amod_t           OFF_V = amod_t'(OFF);
  localparam amod_t           HALF_V  = amod_t'(HALF);
  localparam amod_t           QUART_V = amod_t'(QUART);
  localparam logic [IFRAC:0]  KGAIN = cordic_gain(CORDIC_STEPS);
  localparam logic [62:0]     ZRND  = 63'(64'd1 << (FRAC_BITS - 1));
  localparam trig_t           TRIG_LIM = 32'sd1074790400;  // 2^30 + 2^20

  // offset so the reduction only ever subtracts
  sc_ctl_t in_ctl_q;
  amod_t   in_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else if (en_i) begin
      in_ctl_q <= '{vld: vld_i, neg_s: 1'b0, neg_c: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_v_q <= amod_t'({{(AW-FW){angle_i[FW-1]}}, angle_i}) + OFF_V;
    end
  end

  // reduction chain
  sc_ctl_t red_ctl [RED_STEPS+1];
  amod_t   red_v   [RED_STEPS+1];

  assign red_ctl[0] = in_ctl_q;
  assign red_v[0]   = in_v_q;

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    etrs_mod_cell #(
      .SUB(amod_t'(FULL << (RED_STEPS - 1 - k)))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .ctl_i (red_ctl[k]),
      .val_i (red_v[k]),
      .ctl_o (red_ctl[k+1]),
      .val_o (red_v[k+1])
    );
  end

  // fold into [0, 90] degrees
  sc_ctl_t f1_ctl_d, f1_ctl_q, f2_ctl_d, f2_ctl_q, zp_ctl_q, z_ctl_q;
  amod_t   f1_m_d, f1_m_q, f2_t_d;
  logic [31:0] f2_t_q;
  logic [61:0] zp_q;
  logic [62:0] z_sum;
  logic [62:0] z_shr;
  zang_t       z_q;

  always_comb begin
    f1_ctl_d = red_ctl[RED_STEPS];
    f1_m_d   = red_v[RED_STEPS];
    if (red_v[RED_STEPS] >= HALF_V) begin
      f1_m_d         = red_v[RED_STEPS] - HALF_V;
      f1_ctl_d.neg_s = 1'b1;
      f1_ctl_d.neg_c = 1'b1;
    end
  end

  always_comb begin
    f2_ctl_d = f1_ctl_q;
    f2_t_d   = f1_m_q;
    if (f1_m_q > QUART_V) begin
      f2_t_d         = HALF_V - f1_m_q;
      f2_ctl_d.neg_c = ~f1_ctl_q.neg_c;
    end
  end

  assign z_sum = {1'b0, zp_q} + ZRND;
  assign z_shr = z_sum >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q <= '0;
      f2_ctl_q <= '0;
      zp_ctl_q <= '0;
      z_ctl_q  <= '0;
    end else if (en_i) begin
      f1_ctl_q <= f1_ctl_d;
      f2_ctl_q <= f2_ctl_d;
      zp_ctl_q <= f2_ctl_q;
      z_ctl_q  <= zp_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_m_q <= f1_m_d;
      f2_t_q <= f2_t_d[31:0];
      zp_q   <= {30'd0, f2_t_q} * {32'd0, NDEG_PER_DEG};
      z_q    <= zang_t'(z_shr[ZW-1:0]);
    end
  end

  // cordic chain
  sc_ctl_t cor_ctl [CORDIC_STEPS+1];
  cxy_t    cor_x   [CORDIC_STEPS+1];
  cxy_t    cor_y   [CORDIC_STEPS+1];
  zang_t   cor_z   [CORDIC_STEPS+1];

  assign cor_ctl[0] = z_ctl_q;
  assign cor_x[0]   = cxy_t'({{(XW-IFRAC-1){1'b0}}, KGAIN});
  assign cor_y[0]   = '0;
  assign cor_z[0]   = z_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    etrs_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .ctl_i (cor_ctl[i]),
      .x_i   (cor_x[i]),
      .y_i   (cor_y[i]),
      .z_i   (cor_z[i]),
      .ctl_o (cor_ctl[i+1]),
      .x_o   (cor_x[i+1]),
      .y_o   (cor_y[i+1]),
      .z_o   (cor_z[i+1])
    );
  end

  // quadrant signs
  cxy_t  s_full, c_full;
  logic  vld_q;
  trig_t sin_q, cos_q;

  assign s_full = cor_ctl[CORDIC_STEPS].neg_s ? -cor_y[CORDIC_STEPS] : cor_y[CORDIC_STEPS];
  assign c_full = cor_ctl[CORDIC_STEPS].neg_c ? -cor_x[CORDIC_STEPS] : cor_x[CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cor_ctl[CORDIC_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= s_full[TRIG_W-1:0];
      cos_q <= c_full[TRIG_W-1:0];
    end
  end

  assign vld_o = vld_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;

  `ETRS_ASSERT_IMPL(a_sin_range, vld_q, (sin_q <= TRIG_LIM) && (sin_q >= -TRIG_LIM))
  `ETRS_ASSERT_IMPL(a_cos_range, vld_q, (cos_q <= TRIG_LIM) && (cos_q >= -TRIG_LIM))

endmodule

[hdl/euler_trs_model_matrix.sv]
// ----------------------------------------------------------------------------
// euler_trs_model_matrix: translate-rotate-scale model matrix of a pose
// z-y-x euler rotation with cordic trig, scaled columns, position column
// ----------------------------------------------------------------------------
//
//  channel   dir  beat payload (low bits first)
//  s_axis    in   pos_x pos_y pos_z angle_x angle_y angle_z scale_x scale_y scale_z
//  m_axis    out  rows 0..2 of the matrix, four columns per row, row 0 first
//
//  one pose per cycle while the output buffer has room; the whole datapath is
//  a chain of registered cells: input register, reduction cells, fold and
//  angle registers, cordic cells, sign register, stages p1 to p5, output buffer
//  RED_STEPS is the number of restoring cells that reduce an angle
//  modulo 360 degrees (8 at FRAC_BITS = 16)
//  reset clears only the valid and quadrant sign bits and the output buffer pointers and count
//  a two-beat output buffer lets input beats in while a result waits; the
//  chain stalls as a whole once the buffer is full
//
`include "euler_trs_model_matrix_defines.svh"

module euler_trs_model_matrix #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_r0_c0..m_r0_c3, m_r1_c0..m_r1_c3, m_r2_c0..m_r2_c3
  output logic [383:0] m_axis_tdata
);
  import etrs_pkg::*;

  localparam longint unsigned FULL = 64'd360 << FRAC_BITS;
  localparam longint unsigned OFF  = FULL * (((64'd1 << 31) + FULL - 64'd1) / FULL);
  localparam longint unsigned QMAX = ((64'd1 << 31) - 64'd1 + OFF) / FULL;
  localparam int RED_STEPS = $clog2(QMAX + 64'd1);
  localparam int SC_LAT    = RED_STEPS + CORDIC_STEPS + 6;
  localparam int SIDE_LAT  = SC_LAT + 3;
  localparam int OUT_W     = 12 * FW;

  // global advance: the chain moves whenever the output buffer has room
  logic       en;
  logic       push, pop;
  logic [1:0] cnt_q;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // input fields
  field_t in_f [9];
  for (genvar k = 0; k < 9; k++) begin : g_in
    assign in_f[k] = s_axis_tdata[FW*k +: FW];
  end

  logic in_vld;
  assign in_vld = s_axis_tvalid & en;

  // trig units, one per axis, in lockstep
  logic  sc_vld_x, sc_vld_y, sc_vld_z;
  trig_t sx, cx, sy, cy, sz, cz;

  etrs_sincos #(
    .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .RED_STEPS(RED_STEPS)
  ) u_sc_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(in_vld),
    .angle_i(in_f[3]), .vld_o(sc_vld_x), .sin_o(sx), .cos_o(cx)
  );

  etrs_sincos #(
    .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .RED_STEPS(RED_STEPS)
  ) u_sc_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(in_vld),
    .angle_i(in_f[4]), .vld_o(sc_vld_y), .sin_o(sy), .cos_o(cy)
  );

  etrs_sincos #(
    .FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .RED_STEPS(RED_STEPS)
  ) u_sc_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(in_vld),
    .angle_i(in_f[5]), .vld_o(sc_vld_z), .sin_o(sz), .cos_o(cz)
  );

  // position and scale ride a delay line alongside the trig path
  side_t side_q [SIDE_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{pos_x: in_f[0], pos_y: in_f[1], pos_z: in_f[2],
                     scale_x: in_f[6], scale_y: in_f[7], scale_z: in_f[8]};
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage p1: pairwise products
  logic  p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q;
  prod_t p1_czcy_q, p1_szcy_q, p1_czsy_q, p1_szsy_q, p1_szcx_q, p1_szsx_q;
  prod_t p1_czcx_q, p1_czsx_q, p1_cysx_q, p1_cycx_q;
  trig_t p1_sx_q, p1_cx_q, p1_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_czcy_q <= mulq(cz, cy);
      p1_szcy_q <= mulq(sz, cy);
      p1_czsy_q <= mulq(cz, sy);
      p1_szsy_q <= mulq(sz, sy);
      p1_szcx_q <= mulq(sz, cx);
      p1_szsx_q <= mulq(sz, sx);
      p1_czcx_q <= mulq(cz, cx);
      p1_czsx_q <= mulq(cz, sx);
      p1_cysx_q <= mulq(cy, sx);
      p1_cycx_q <= mulq(cy, cx);
      p1_sx_q   <= sx;
      p1_cx_q   <= cx;
      p1_sy_q   <= sy;
    end
  end

  // stage p2: third factor of the mixed terms
  prod_t p2_t1_q, p2_t2_q, p2_t3_q, p2_t4_q;
  prod_t p2_czcy_q, p2_szcy_q, p2_szcx_q, p2_szsx_q, p2_czcx_q, p2_czsx_q;
  prod_t p2_cysx_q, p2_cycx_q;
  trig_t p2_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_t1_q   <= mulq(trig_t'(p1_czsy_q[TRIG_W-1:0]), p1_sx_q);
      p2_t2_q   <= mulq(trig_t'(p1_czsy_q[TRIG_W-1:0]), p1_cx_q);
      p2_t3_q   <= mulq(trig_t'(p1_szsy_q[TRIG_W-1:0]), p1_sx_q);
      p2_t4_q   <= mulq(trig_t'(p1_szsy_q[TRIG_W-1:0]), p1_cx_q);
      p2_czcy_q <= p1_czcy_q;
      p2_szcy_q <= p1_szcy_q;
      p2_szcx_q <= p1_szcx_q;
      p2_szsx_q <= p1_szsx_q;
      p2_czcx_q <= p1_czcx_q;
      p2_czsx_q <= p1_czsx_q;
      p2_cysx_q <= p1_cysx_q;
      p2_cycx_q <= p1_cycx_q;
      p2_sy_q   <= p1_sy_q;
    end
  end

  // stage p3: rotation matrix R = Rz * Ry * Rx, row major
  relem_t r_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0] <= relem_t'(p2_czcy_q);
      r_q[1] <= relem_t'(p2_t1_q) - relem_t'(p2_szcx_q);
      r_q[2] <= relem_t'(p2_t2_q) + relem_t'(p2_szsx_q);
      r_q[3] <= relem_t'(p2_szcy_q);
      r_q[4] <= relem_t'(p2_t3_q) + relem_t'(p2_czcx_q);
      r_q[5] <= relem_t'(p2_t4_q) - relem_t'(p2_czsx_q);
      r_q[6] <= -relem_t'(p2_sy_q);
      r_q[7] <= relem_t'(p2_cysx_q);
      r_q[8] <= relem_t'(p2_cycx_q);
    end
  end

  // stage p4: column scaling
  side_t  side_last;
  field_t scl [3];
  wide_t  p4_pr_q [9];
  field_t p4_pos_q [3];

  assign side_last = side_q[SIDE_LAT-1];
  assign scl[0]    = side_last.scale_x;
  assign scl[1]    = side_last.scale_y;
  assign scl[2]    = side_last.scale_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        p4_pr_q[k] <= wide_t'(r_q[k]) * wide_t'(scl[k % 3]);
      end
      p4_pos_q[0] <= side_last.pos_x;
      p4_pos_q[1] <= side_last.pos_y;
      p4_pos_q[2] <= side_last.pos_z;
    end
  end

  // stage p5: round to nearest, saturate, pack the beat
  wide_t             rnd [9];
  field_t            elem [9];
  logic [OUT_W-1:0]  p5_data_d, p5_data_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd[k] = p4_pr_q[k] + 66'sd536870912;
      if ((rnd[k][WW-1:61] == '0) || (rnd[k][WW-1:61] == '1)) begin
        elem[k] = field_t'(rnd[k][61:30]);
      end else if (rnd[k][WW-1]) begin
        elem[k] = 32'sh8000_0000;
      end else begin
        elem[k] = 32'sh7fff_ffff;
      end
    end
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        p5_data_d[FW*(row*4+col) +: FW] = elem[row*3+col];
      end
      p5_data_d[FW*(row*4+3) +: FW] = p4_pos_q[row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_data_q <= p5_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= sc_vld_x;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  // two-beat output buffer
  logic [OUT_W-1:0] obuf_q [2];
  logic             wr_q, rd_q;

  assign push = en & p5_vld_q;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      obuf_q[wr_q] <= p5_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = obuf_q[rd_q];

  `ETRS_ASSERT(a_sc_lockstep, (sc_vld_x == sc_vld_y) && (sc_vld_x == sc_vld_z))
  `ETRS_ASSERT(a_obuf_cnt, cnt_q != 2'd3)
  `ETRS_ASSERT_NEXT(a_full_blocks, (cnt_q == 2'd2) && !pop, !s_axis_tready)
  `ETRS_ASSERT_NEXT(a_push_shows, push && (cnt_q == 2'd0), m_axis_tvalid)

endmodule

[bench/tb_euler_trs_model_matrix.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_trs_model_matrix: self-checking bench of the pose matrix block
// drives full poses over the input stream and predicts every matrix
// (cordic trig, z-y-x rotation, scaled columns, position column) in
// the bench; each output beat is compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb_euler_trs_model_matrix;
  import etrs_pkg::*;

  localparam int LATENCY   = 35;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1400;
  localparam longint ONE   = 64'sd65536;
  localparam longint DEG   = 64'sd65536;

  localparam longint ATAN_TBL [24] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
    64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
    64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
    64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283,
    64'sd54642,       64'sd27321,       64'sd13660,       64'sd6830
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;  // pos xyz, angle xyz, scale xyz
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [383:0] m_axis_tdata;       // rows 0..2, columns 0..3

  logic [383:0] matrix_q[$];        // matrices still owed by the block
  int           n_errors = 0;
  int           n_sent = 0;
  int           n_matrices = 0;
  int           idle_cycles = 0;
  bit           steady = 1'b0;      // no stalls on either side
  int           sink_wait = 0;
  longint       k_gain;

  always #10 clk_i = ~clk_i;

  euler_trs_model_matrix dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // ---------------- predictor ----------------

  function automatic longint cordic_start();
    longint unsigned g;
    longint unsigned k;
    longint unsigned t;
    g = 64'd1 << 30;
    k = 0;
    for (int i = 0; i < 16; i++) g = g + (g >> (2 * i));
    for (int i = 29; i >= 0; i--) begin
      t = k | (64'd1 << i);
      if (((t * t) >> 30) * g <= (64'd1 << 60)) k = t;
    end
    return longint'(k);
  endfunction

  function automatic void angle_trig(input longint a, output longint s, output longint c);
    longint m;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     ns;
    bit     nc;
    m = a % (360 * DEG);
    ns = 0;
    nc = 0;
    if (m < 0) m += 360 * DEG;
    // fold into the first quadrant, tracking the signs
    if (m >= 180 * DEG) begin
      m -= 180 * DEG;
      ns = 1;
      nc = 1;
    end
    if (m > 90 * DEG) begin
      m = 180 * DEG - m;
      nc = ~nc;
    end
    z = (m * 1000000000 + 32768) >>> 16;
    x = k_gain;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TBL[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TBL[i];
      end
    end
    s = ns ? -y : y;
    c = nc ? -x : x;
  endfunction

  function automatic longint q30(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [31:0] scale_elem(input longint r, input longint sc);
    longint v;
    v = (r * sc + 64'sd536870912) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [383:0] trs_matrix(input logic [287:0] pose);
    longint sx, cx, sy, cy, sz, cz;
    longint rot[9];
    longint scl[3];
    logic [383:0] m;
    angle_trig(longint'($signed(pose[96+:32])), sx, cx);
    angle_trig(longint'($signed(pose[128+:32])), sy, cy);
    angle_trig(longint'($signed(pose[160+:32])), sz, cz);
    for (int c = 0; c < 3; c++) scl[c] = longint'($signed(pose[192 + 32 * c +: 32]));
    rot[0] = q30(cz, cy);
    rot[1] = q30(q30(cz, sy), sx) - q30(sz, cx);
    rot[2] = q30(q30(cz, sy), cx) + q30(sz, sx);
    rot[3] = q30(sz, cy);
    rot[4] = q30(q30(sz, sy), sx) + q30(cz, cx);
    rot[5] = q30(q30(sz, sy), cx) - q30(cz, sx);
    rot[6] = -sy;
    rot[7] = q30(cy, sx);
    rot[8] = q30(cy, cx);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) m[128 * r + 32 * c +: 32] = scale_elem(rot[3 * r + c], scl[c]);
      m[128 * r + 96 +: 32] = pose[32 * r +: 32];
    end
    return m;
  endfunction

  // ---------------- driving and checking ----------------

  task automatic report_mismatch(input int idx, input logic [31:0] want, input logic [31:0] got);
    n_errors++;
    $display("mismatch matrix %0d m_r%0d_c%0d: expected %h got %h",
             n_matrices, idx / 4, idx % 4, want, got);
  endtask

  // one pose beat; valid stays high between back-to-back beats
  task automatic send_pose(input logic [287:0] pose);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pose;
    do @(posedge clk_i); while (!s_axis_tready);
    matrix_q.push_back(trs_matrix(pose));
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [287:0] make_pose(input logic [31:0] f[9]);
    logic [287:0] p;
    for (int i = 0; i < 9; i++) p[32 * i +: 32] = f[i];
    return p;
  endfunction

  function automatic logic [31:0] deg(input int d);
    return 32'(d * 65536);
  endfunction

  // result side: check the beat, then draw the stall before the next one
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        n_errors++;
        $display("unexpected output beat %h", m_axis_tdata);
      end else begin
        logic [383:0] want;
        want = matrix_q.pop_front();
        for (int i = 0; i < 12; i++)
          if (m_axis_tdata[32 * i +: 32] !== want[32 * i +: 32])
            report_mismatch(i, want[32 * i +: 32], m_axis_tdata[32 * i +: 32]);
      end
      n_matrices++;
      sink_wait = steady ? 0 : $urandom_range(0, 10);
    end
    if (rst_ni) m_axis_tready <= (sink_wait == 0);
    if (sink_wait > 0) sink_wait--;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout: no beat for %0d cycles", WDOG_MAX);
      $display("tb_euler_trs_model_matrix NOT OK");
      $finish;
    end
  end

  // ---------------- tests ----------------

  // quadrant angles, huge angles, extreme positions and scales
  task automatic test_directed();
    logic [31:0] f[9];
    int quads[10] = '{0, 90, 180, 270, 360, -90, -180, 45, 135, -225};
    for (int i = 0; i < 10; i++) begin
      f = '{32'(i * 65536), 32'(-i * 65536), 32'h0001_8000,
            deg(quads[i]), deg(quads[(i + 3) % 10]), deg(quads[(i + 7) % 10]),
            32'(ONE), 32'(2 * ONE), 32'(-ONE)};
      send_pose(make_pose(f));
    end
    // largest and smallest field values everywhere
    f = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_pose(make_pose(f));
    f = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_pose(make_pose(f));
    // zero scale, all zero, and the just-past-quadrant angles
    f = '{default: 32'h0};
    send_pose(make_pose(f));
    f = '{32'h0, 32'h0, 32'h0, 32'(90 * 65536 + 1), 32'(180 * 65536 - 1),
          32'(-1), 32'h0, 32'h0, 32'h0};
    send_pose(make_pose(f));
    // saturating scale with a diagonal-heavy rotation
    f = '{32'hffff_ffff, 32'h1, 32'h0, deg(30), deg(-60), deg(10),
          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_pose(make_pose(f));
    f = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, deg(720), deg(-1080), deg(3600),
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_pose(make_pose(f));
  endtask

  // hold off the sender until the block is fully empty
  task automatic test_drain_pause();
    drain();
    repeat (4) send_pose(make_pose('{deg(1), deg(2), deg(3), deg(17), deg(-33), deg(271),
                                     32'(ONE), 32'(ONE), 32'(ONE)}));
    drain();
  endtask

  task automatic test_random(input int n);
    logic [31:0] f[9];
    int mode;
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 2) && (i < n / 2 + 200);
      mode = $urandom_range(0, 3);
      for (int j = 0; j < 9; j++) f[j] = $urandom();
      if (mode == 1) begin
        // ordinary poses: angles within two turns, moderate scale
        for (int j = 3; j < 6; j++) f[j] = 32'(int'($urandom_range(0, 1440 * 65536)) - 720 * 65536);
        for (int j = 6; j < 9; j++) f[j] = 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
      end else if (mode == 2) begin
        // quadrant-aligned angles, plus or minus up to two lsb
        for (int j = 3; j < 6; j++)
          f[j] = 32'(int'($urandom_range(0, 16)) * 90 * 65536 - 720 * 65536 +
                     int'($urandom_range(0, 4)) - 2);
      end
      send_pose(make_pose(f));
    end
    steady = 1'b0;
  endtask

  initial begin
    k_gain = cordic_start();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(N_RANDOM);
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (matrix_q.size() != 0) begin
      n_errors++;
      $display("%0d matrices never arrived", matrix_q.size());
    end
    $display("covered %0d poses: quadrant and huge angles, saturating scales, random poses",
             n_sent);
    $display("%0d matrices checked with random and zero stalls on both sides", n_matrices);
    if (n_errors == 0) begin
      $display("tb_euler_trs_model_matrix OK");
    end else begin
      $display("tb_euler_trs_model_matrix NOT OK");
    end
    $finish;
  end

endmodule
